>>> sv/assert_macros.svh
// assertion macros for the gradient lookup rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CGL_ASSERT(lbl, clk, rst, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CGL_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CGL_ASSERT(lbl, clk, rst, prop, msg)
`define CGL_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

>>> sv/cgl_pkg.sv
// shared types, constants and helper functions for the color gradient lookup
// no dependencies
`timescale 1ns / 1ps

package cgl_pkg;

   localparam int MAX_STOPS  = 6;
   localparam int STOP_IDX_W = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CSR_IDX_W  = $clog2(MAX_STOPS + 1);
   localparam int COUNT_W    = 3;
   localparam int STOP_W     = 40;
   localparam int POS_W      = 16;
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int C565_W     = 16;
   localparam int BIAS_W     = 16;
   localparam int DIV_CNT_W  = 4;
   localparam int PROD_W     = CHAN_W + BIAS_W;

   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_STOP_0     = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_MULT,
      ST_BLEND,
      ST_PACK
   } cgl_state_type;

   typedef struct packed {
      logic load;
      logic search;
      logic div_step;
      logic mult;
      logic blend;
      logic pack;
   } cgl_cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic direct;
      logic last;
      logic div_last;
   } cgl_stat_type;

   function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] s);
      return s[STOP_W-1 -: POS_W];
   endfunction

   // channel 0 is red in bits 23..16, then green, then blue
   function automatic logic [CHAN_W-1:0] stop_chan(input logic [STOP_W-1:0] s, input int c);
      return s[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W];
   endfunction

   // floor(y / 255) for y well below 65535
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] y);
      logic [16:0] t;
      t = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   function automatic logic [C565_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                 input logic [CHAN_W-1:0] g,
                                                 input logic [CHAN_W-1:0] b);
      logic [15:0] r31;
      logic [15:0] g63;
      logic [15:0] b31;
      logic [CHAN_W-1:0] r5;
      logic [CHAN_W-1:0] g6;
      logic [CHAN_W-1:0] b5;
      r31 = ({8'd0, r} << 5) - {8'd0, r};
      g63 = ({8'd0, g} << 6) - {8'd0, g};
      b31 = ({8'd0, b} << 5) - {8'd0, b};
      r5  = div255(r31);
      g6  = div255(g63);
      b5  = div255(b31);
      return {r5[4:0], g6[5:0], b5[4:0]};
   endfunction

endpackage

>>> sv/cgl_if.sv
// valid/ready channel interfaces for the gradient lookup request and response
// depends on cgl_pkg
`timescale 1ns / 1ps

interface cgl_req_if import cgl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink (input valid, input position, output ready);
endinterface

interface cgl_rsp_if import cgl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic [C565_W-1:0] color565;

   modport source (output valid, output red, output green, output blue, output color565,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input color565,
                 output ready);
endinterface

>>> sv/color_gradient_lookup_unit.sv
// Color gradient lookup: maps a 16-bit position onto a piecewise-linear color
// ramp of up to six stops and returns 8-bit red, green, blue plus the RGB565
// packing. One position is worked at a time. A position that lands on a stop,
// before the first stop or past the last one goes from the search straight to
// pack, and with no stops in use the unit goes from accept straight to pack with
// black. A position between stops is searched stop by stop, then the blend
// weight is formed in the one-bit-per-cycle restoring divider, then multiply,
// blend and pack follow. The next position is accepted while the previous
// result still waits in the output register; its pack state stretches until
// that result leaves. Stops and the stop count must be written through the csr
// port only while the unit is idle; the unit itself does not enforce this.
// Index 0 is the count, 1 to 6 the stops.
// depends on cgl_pkg, cgl_if, cgl_ctrl and cgl_dp
`timescale 1ns / 1ps

module color_gradient_lookup_unit import cgl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STOP_W-1:0]    csr_wdata,
   cgl_req_if.sink              req_chan,
   cgl_rsp_if.source            rsp_chan
);

   cgl_cmd_type  cmd;
   cgl_stat_type stat;

   cgl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cgl_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_position (req_chan.position),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_red      (rsp_chan.red),
      .rsp_green    (rsp_chan.green),
      .rsp_blue     (rsp_chan.blue),
      .rsp_color565 (rsp_chan.color565)
   );

endmodule

>>> sv/cgl_ctrl.sv
// sequencing state machine for the gradient lookup: search, divide, multiply, blend, pack
// depends on cgl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cgl_ctrl import cgl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output cgl_cmd_type  cmd,
   input  cgl_stat_type stat
);

   cgl_state_type state_ff;
   cgl_state_type state_in;
   logic          out_valid_ff;
   logic          out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.empty ? ST_PACK : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.hit) begin
               state_in = stat.direct ? ST_PACK : ST_DIVIDE;
            end else if (stat.last) begin
               state_in = ST_PACK;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_PACK;
         ST_PACK: begin
            if (!out_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SEARCH: cmd.search   = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_MULT:   cmd.mult     = 1'b1;
         ST_BLEND:  cmd.blend    = 1'b1;
         ST_PACK:   cmd.pack     = !out_valid_ff || rsp_ready;
         default:   cmd          = '0;
      endcase
      // output register refills in the same cycle its beat leaves
      if (cmd.pack) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   `CGL_ASSERT(a_pack_waits, clock, reset, (state_ff == ST_PACK && out_valid_ff && !rsp_ready) |=> (state_ff == ST_PACK), "pack overwrote a pending beat")
   `CGL_ASSERT(a_accept_next, clock, reset, (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_SEARCH || state_ff == ST_PACK), "bad state after accept")
   `CGL_ASSERT(a_divide_len, clock, reset, (state_ff == ST_DIVIDE && !stat.div_last) |=> (state_ff == ST_DIVIDE), "divide left early")
   `CGL_ASSERT_NEVER(a_mult_after_div, clock, reset, state_ff == ST_MULT && $past(state_ff) != ST_DIVIDE, "multiply without divide")

endmodule

>>> sv/cgl_dp.sv
// datapath of the gradient lookup: stop registers, search, bit-serial divider,
// channel blend and rgb565 packing; depends on cgl_pkg
`timescale 1ns / 1ps

module cgl_dp import cgl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STOP_W-1:0]    csr_wdata,
   input  logic [POS_W-1:0]     req_position,
   input  cgl_cmd_type          cmd,
   output cgl_stat_type         stat,
   output logic [CHAN_W-1:0]    rsp_red,
   output logic [CHAN_W-1:0]    rsp_green,
   output logic [CHAN_W-1:0]    rsp_blue,
   output logic [C565_W-1:0]    rsp_color565
);

   logic [COUNT_W-1:0]    count_ff;
   logic [STOP_W-1:0]     stop_ff [MAX_STOPS];
   logic [CSR_IDX_W-1:0]  wr_off;

   logic [POS_W-1:0]      pos_ff;
   logic [STOP_IDX_W-1:0] idx_ff;
   logic [STOP_W-1:0]     prev_ff;
   logic [STOP_W-1:0]     cur_ff;
   logic [POS_W-1:0]      rem_ff;
   logic [POS_W-1:0]      dist_ff;
   logic [BIAS_W-1:0]     bias_ff;
   logic [DIV_CNT_W-1:0]  dcnt_ff;
   logic [PROD_W-1:0]     prod_ff [NUM_CHAN];
   logic                  neg_ff  [NUM_CHAN];
   logic [CHAN_W-1:0]     rgb_ff  [NUM_CHAN];
   logic [CHAN_W-1:0]     red_ff;
   logic [CHAN_W-1:0]     green_ff;
   logic [CHAN_W-1:0]     blue_ff;
   logic [C565_W-1:0]     c565_ff;

   logic [COUNT_W-1:0]    n_eff;
   logic [STOP_W-1:0]     cur_stop;
   logic [POS_W-1:0]      cur_p;
   logic [POS_W:0]        rem2;
   logic                  ge;

   assign wr_off = csr_index - REG_STOP_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < MAX_STOPS; i++) begin
            stop_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == REG_STOP_COUNT) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end else if (csr_index <= CSR_IDX_W'(MAX_STOPS)) begin
            stop_ff[wr_off[STOP_IDX_W-1:0]] <= csr_wdata;
         end
      end
   end

   assign n_eff    = (count_ff > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : count_ff;
   assign cur_stop = stop_ff[idx_ff];
   assign cur_p    = stop_pos(cur_stop);

   assign stat.empty    = (n_eff == '0);
   assign stat.hit      = (cur_p >= pos_ff);
   assign stat.direct   = (cur_p == pos_ff) || (idx_ff == '0);
   assign stat.last     = (COUNT_W'(idx_ff) == n_eff - COUNT_W'(1));
   assign stat.div_last = (dcnt_ff == DIV_CNT_W'(BIAS_W - 1));

   // restoring step, remainder stays below the divisor
   assign rem2 = {rem_ff, 1'b0};
   assign ge   = (rem2 >= {1'b0, dist_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff <= req_position;
         idx_ff <= '0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            rgb_ff[c] <= '0;
         end
      end
      if (cmd.search) begin
         // direct and past-the-end cases take the stop color as is
         for (int c = 0; c < NUM_CHAN; c++) begin
            rgb_ff[c] <= stop_chan(cur_stop, c);
         end
         if (stat.hit) begin
            cur_ff  <= cur_stop;
            rem_ff  <= pos_ff - stop_pos(prev_ff);
            dist_ff <= cur_p - stop_pos(prev_ff);
            dcnt_ff <= '0;
         end else begin
            prev_ff <= cur_stop;
            idx_ff  <= idx_ff + STOP_IDX_W'(1);
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= ge ? POS_W'(rem2 - {1'b0, dist_ff}) : rem2[POS_W-1:0];
         bias_ff <= {bias_ff[BIAS_W-2:0], ge};
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.mult) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (stop_chan(cur_ff, c) < stop_chan(prev_ff, c)) begin
               neg_ff[c]  <= 1'b1;
               prod_ff[c] <= PROD_W'(stop_chan(prev_ff, c) - stop_chan(cur_ff, c))
                             * PROD_W'(bias_ff);
            end else begin
               neg_ff[c]  <= 1'b0;
               prod_ff[c] <= PROD_W'(stop_chan(cur_ff, c) - stop_chan(prev_ff, c))
                             * PROD_W'(bias_ff);
            end
         end
      end
      if (cmd.blend) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            rgb_ff[c] <= neg_ff[c] ? stop_chan(prev_ff, c) - prod_ff[c][PROD_W-1 -: CHAN_W]
                                   : stop_chan(prev_ff, c) + prod_ff[c][PROD_W-1 -: CHAN_W];
         end
      end
      if (cmd.pack) begin
         red_ff   <= rgb_ff[0];
         green_ff <= rgb_ff[1];
         blue_ff  <= rgb_ff[2];
         c565_ff  <= pack565(rgb_ff[0], rgb_ff[1], rgb_ff[2]);
      end
   end

   assign rsp_red      = red_ff;
   assign rsp_green    = green_ff;
   assign rsp_blue     = blue_ff;
   assign rsp_color565 = c565_ff;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for color_gradient_lookup_unit: random ramps, positions and stalls
// depends on cgl_pkg, cgl_if and the unit rtl; expected colors come from a scoreboard class
`timescale 1ns / 1ps

module tb_top import cgl_pkg::*; ();

   localparam int QUIET_LIMIT = 2000;
   localparam int RAMP_PHASES = 12;
   localparam int PHASE_ITEMS = 150;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(MAX_STOPS + 1);

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [C565_W-1:0] c565;
   } ramp_color_type;

   typedef struct {
      logic [CSR_IDX_W-1:0] idx;
      logic [STOP_W-1:0]    data;
   } csr_write_type;

   class ramp_scoreboard;
      logic [COUNT_W-1:0] stop_count;
      logic [STOP_W-1:0]  stop_regs[MAX_STOPS];
      ramp_color_type     expected_colors[$];
      int                 mismatches;

      function new();
         stop_count = '0;
         foreach (stop_regs[i]) stop_regs[i] = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [STOP_W-1:0] data);
         if (idx == REG_STOP_COUNT)
            stop_count = data[COUNT_W-1:0];
         else if (idx <= CSR_IDX_W'(MAX_STOPS))
            stop_regs[STOP_IDX_W'(idx - REG_STOP_0)] = data;
      endfunction

      function ramp_color_type ramp_color(logic [POS_W-1:0] pos);
         ramp_color_type res;
         int n;
         int sel;
         logic [POS_W-1:0]  pp;
         logic [POS_W-1:0]  pc;
         logic [31:0]       bias;
         logic [CHAN_W-1:0] a;
         logic [CHAN_W-1:0] b;
         logic [CHAN_W-1:0] ch[NUM_CHAN];
         n = (stop_count > MAX_STOPS) ? MAX_STOPS : int'(stop_count);
         foreach (ch[c]) ch[c] = '0;
         if (n > 0) begin
            // first stop at or above the position
            sel = n;
            for (int i = n - 1; i >= 0; i--)
               if (stop_regs[i][39:24] >= pos) sel = i;
            if (sel == n) begin
               foreach (ch[c]) ch[c] = stop_regs[n-1][23 - 8*c -: 8];
            end else if (sel == 0 || stop_regs[sel][39:24] == pos) begin
               foreach (ch[c]) ch[c] = stop_regs[sel][23 - 8*c -: 8];
            end else begin
               pp   = stop_regs[sel-1][39:24];
               pc   = stop_regs[sel][39:24];
               bias = (32'(pos - pp) << 16) / 32'(pc - pp);
               foreach (ch[c]) begin
                  a = stop_regs[sel-1][23 - 8*c -: 8];
                  b = stop_regs[sel][23 - 8*c -: 8];
                  // magnitude scaled then truncated, so rounding is toward the earlier stop
                  if (b >= a)
                     ch[c] = a + CHAN_W'(((32'(b) - 32'(a)) * bias) >> 16);
                  else
                     ch[c] = a - CHAN_W'(((32'(a) - 32'(b)) * bias) >> 16);
               end
            end
         end
         res.red   = ch[0];
         res.green = ch[1];
         res.blue  = ch[2];
         res.c565  = {5'((32'(ch[0]) * 31) / 255), 6'((32'(ch[1]) * 63) / 255),
                      5'((32'(ch[2]) * 31) / 255)};
         return res;
      endfunction

      function void note_position(logic [POS_W-1:0] pos);
         expected_colors.push_back(ramp_color(pos));
      endfunction

      function void check_color(ramp_color_type got);
         ramp_color_type want;
         if (expected_colors.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_colors.pop_front();
         if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatches++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatches++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
         end
         if (got.c565 !== want.c565) begin
            $error("color565: expected %h, got %h", want.c565, got.c565);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STOP_W-1:0]    csr_wdata;

   cgl_req_if req_bus ();
   cgl_rsp_if rsp_bus ();

   color_gradient_lookup_unit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   ramp_scoreboard   sb;
   stall_mode_type   stall_mode;
   bit               req_steady;
   int               burst_left;
   int               ready_run;
   int               quiet_cycles;
   logic [POS_W-1:0] ramp_pos[MAX_STOPS];

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [CHAN_W-1:0] pick_channel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [STOP_W-1:0] stop_word(logic [POS_W-1:0] pos, logic [7:0] r,
                                                   logic [7:0] g, logic [7:0] b);
      return {pos, r, g, b};
   endfunction

   task automatic csr_burst(input csr_write_type writes[$]);
      foreach (writes[k]) begin
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = writes[k].idx;
         csr_wdata = writes[k].data;
         @(posedge clock);
         sb.write_reg(writes[k].idx, writes[k].data);
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_position(input logic [POS_W-1:0] pos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (req_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid    = 1'b1;
      req_bus.position = pos;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_bus.valid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response ready follows its own stall pattern
   always @(negedge clock) begin
      if (ready_run > 0) begin
         ready_run--;
      end else begin
         case (stall_mode)
            STALL_NONE: rsp_bus.ready = 1'b1;
            STALL_RANDOM: rsp_bus.ready = 1'($urandom_range(0, 1));
            default: begin
               rsp_bus.ready = !rsp_bus.ready;
               ready_run = rsp_bus.ready ? $urandom_range(0, 6) : $urandom_range(0, 35);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      ramp_color_type got;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            sb.note_position(req_bus.position);
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.red   = rsp_bus.red;
            got.green = rsp_bus.green;
            got.blue  = rsp_bus.blue;
            got.c565  = rsp_bus.color565;
            sb.check_color(got);
            quiet_cycles = 0;
         end
         if (csr_we) quiet_cycles = 0;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      csr_write_type    w[$];
      logic [POS_W-1:0] dir[$];
      logic [POS_W-1:0] p[$];
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] base;
      logic [COUNT_W-1:0] cnt;
      int r;
      int k;
      int shape;

      sb               = new();
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_bus.valid    = 1'b0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      stall_mode       = STALL_BURSTY;
      req_steady       = 1'b0;
      burst_left       = 0;
      ready_run        = 0;
      quiet_cycles     = 0;
      foreach (ramp_pos[i]) ramp_pos[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no stops after reset: everything is black
      dir = {16'h0000, 16'hFFFF, 16'h1234};
      foreach (dir[i]) send_position(dir[i]);
      finish_phase();

      // three stops, red to green to blue
      w = {};
      w.push_back('{REG_STOP_0, stop_word(16'h1000, 8'hFF, 8'h00, 8'h00)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(1), stop_word(16'h8000, 8'h00, 8'hFF, 8'h00)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(2), stop_word(16'hF000, 8'h00, 8'h00, 8'hFF)});
      w.push_back('{REG_STOP_COUNT, 40'd3});
      csr_burst(w);
      stall_mode = STALL_RANDOM;
      dir = {16'h0000, 16'h1000, 16'h4000, 16'h8000, 16'hA000, 16'hF000, 16'hFFFF,
             16'h8001, 16'hEFFF};
      foreach (dir[i]) send_position(dir[i]);
      finish_phase();

      // count above the stop limit, unit-distance stops, falling channels,
      // and a write to the unused index that must change nothing
      w = {};
      w.push_back('{REG_STOP_0, stop_word(16'h0000, 8'hFF, 8'hFF, 8'hFF)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(1), stop_word(16'h0001, 8'h00, 8'h00, 8'h00)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(2), stop_word(16'h3333, 8'd200, 8'd17, 8'd90)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(3), stop_word(16'h7FFF, 8'd3, 8'd250, 8'd128)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(4), stop_word(16'hFFFE, 8'hFF, 8'h00, 8'd7)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(5), stop_word(16'hFFFF, 8'h00, 8'hFF, 8'h00)});
      w.push_back('{REG_STOP_COUNT, 40'd7});
      w.push_back('{REG_UNUSED, '1});
      csr_burst(w);
      stall_mode = STALL_NONE;
      dir = {16'h0000, 16'h2000, 16'h5000, 16'hC000, 16'hFFFF, 16'hFFFE};
      foreach (dir[i]) send_position(dir[i]);
      finish_phase();

      // stops out of order
      w = {};
      w.push_back('{REG_STOP_0, stop_word(16'h9000, 8'd10, 8'd20, 8'd30)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(1), stop_word(16'h2000, 8'hFF, 8'd100, 8'h00)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(2), stop_word(16'hC000, 8'h00, 8'd160, 8'hFF)});
      w.push_back('{REG_STOP_0 + CSR_IDX_W'(3), stop_word(16'h4000, 8'd77, 8'd88, 8'd99)});
      w.push_back('{REG_STOP_COUNT, 40'd4});
      csr_burst(w);
      stall_mode = STALL_BURSTY;
      dir = {16'h1000, 16'hA000, 16'hD000, 16'h9000};
      foreach (dir[i]) send_position(dir[i]);
      finish_phase();

      for (int phase = 0; phase < RAMP_PHASES; phase++) begin
         r = $urandom_range(0, 9);
         cnt = (r == 0) ? 3'd0 : (r == 1) ? 3'd7 : COUNT_W'($urandom_range(1, MAX_STOPS));
         shape = $urandom_range(0, 7);
         p = {};
         base = POS_W'($urandom_range(0, 65535 - 32));
         for (int i = 0; i < MAX_STOPS; i++) begin
            if (shape == 4)
               p.push_back(base + POS_W'(i * $urandom_range(0, 3)));
            else
               p.push_back(POS_W'($urandom_range(0, 65535)));
         end
         // shape 6 leaves the stops unsorted
         if (shape != 6) p.sort();
         if (shape == 5) begin
            p[0] = '0;
            p[MAX_STOPS-1] = '1;
         end
         if (shape == 7) begin
            p[2] = p[1];
            p[4] = p[3];
         end
         w = {};
         if ($urandom_range(0, 1)) w.push_back('{REG_STOP_COUNT, STOP_W'(cnt)});
         for (int i = 0; i < MAX_STOPS; i++) begin
            ramp_pos[i] = p[i];
            w.push_back('{REG_STOP_0 + CSR_IDX_W'(i),
                          stop_word(p[i], pick_channel(), pick_channel(), pick_channel())});
         end
         if ($urandom_range(0, 2) == 0)
            w.push_back('{REG_UNUSED, {$urandom(), 8'($urandom())}});
         if (w[0].idx != REG_STOP_COUNT) w.push_back('{REG_STOP_COUNT, STOP_W'(cnt)});
         csr_burst(w);

         stall_mode = stall_mode_type'(phase % 3);
         req_steady = (phase % 4 == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               pos = ramp_pos[$urandom_range(0, MAX_STOPS - 1)] + POS_W'($urandom_range(0, 2))
                     - 16'd1;
            end else if (r == 4) begin
               pos = $urandom_range(0, 1) ? '1 : '0;
            end else if (r < 7) begin
               k = $urandom_range(0, MAX_STOPS - 2);
               pos = POS_W'($urandom_range(ramp_pos[k], ramp_pos[k+1]));
            end else begin
               pos = POS_W'($urandom_range(0, 65535));
            end
            send_position(pos);
         end
         finish_phase();
      end

      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> color_gradient_lookup_unit.f
+incdir+sv
sv/cgl_pkg.sv
sv/cgl_if.sv
sv/cgl_ctrl.sv
sv/cgl_dp.sv
sv/color_gradient_lookup_unit.sv
verif/tb_top.sv
